/* rtl/qau_pkg.sv */
// Shared types, constants and tables for the quaternion arithmetic unit.
// Used by qau_lane, qau_merge and quaternion_arithmetic_unit_core; no dependencies.
package qau_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_SUB     = 3'd1,
    OP_HAM     = 3'd2,
    OP_SCALE   = 3'd3,
    OP_DIV     = 3'd4,
    OP_CONJ    = 3'd5,
    OP_NORM_SQ = 3'd6,
    OP_NORM    = 3'd7
  } op_t;

  typedef logic signed [WORD_BITS-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  typedef struct packed {
    op_t   func;
    word_t a_w;
    word_t a_x;
    word_t a_y;
    word_t a_z;
    word_t b_w;
    word_t b_x;
    word_t b_y;
    word_t b_z;
    word_t scalar;
  } qau_cmd_t;

  typedef struct packed {
    word_t                res_w;
    word_t                res_x;
    word_t                res_y;
    word_t                res_z;
    logic [WORD_BITS-2:0] res_scalar;
    logic                 overflow;
    logic                 div_zero;
  } qau_res_t;

  // One quaternion part as a lane delivers it.
  typedef struct packed {
    word_t word;
    logic  ovf;
    logic  dz;
  } lane_out_t;

  // Norm or squared norm as the merge stage delivers it.
  typedef struct packed {
    logic [WORD_BITS-2:0] value;
    logic                 ovf;
  } scal_out_t;

  // Hamilton product: part k = sum over j of sign * a[HAM_A[k][j]] * b[HAM_B[k][j]].
  localparam logic [1:0] HAM_A [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd0, 2'd2, 2'd3, 2'd1},
    '{2'd0, 2'd3, 2'd1, 2'd2}
  };
  localparam logic [1:0] HAM_B [4][4] = '{
    '{2'd0, 2'd1, 2'd2, 2'd3},
    '{2'd1, 2'd0, 2'd3, 2'd2},
    '{2'd2, 2'd0, 2'd1, 2'd3},
    '{2'd3, 2'd0, 2'd2, 2'd1}
  };
  localparam logic HAM_NEG [4][4] = '{
    '{1'b0, 1'b1, 1'b1, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b0, 1'b0, 1'b1}
  };

endpackage

/* rtl/quaternion_arithmetic_unit_core.sv */
// Top level of the quaternion arithmetic unit: four part lanes, the norm merge
// stage and the result strobe pipeline. Depends on qau_pkg, qau_lane, qau_merge.
//
// Fully pipelined signed fixed-point quaternion unit (WORD_BITS-bit words with
// FRAC_BITS fraction bits, Q16.16 at the defaults). A word is taken at every
// rising edge where start is high and busy is low; busy is high only while rst
// is asserted, so one word per cycle is sustained. Each word yields exactly one
// result, shown on result for exactly one cycle with done high. The divider in
// each lane resolves one quotient bit per stage over WORD_BITS + FRAC_BITS
// stages; every other operation is delayed to match the divider, so results
// leave in the order the words came in. The receiver cannot hold results off:
// capture result whenever done is high. Products and squared norm round toward
// minus infinity, divide truncates toward zero, the norm is the floor of the
// exact square root; out-of-range values clamp and raise overflow, and a zero
// divisor raises div_zero.
module quaternion_arithmetic_unit_core #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qau_pkg::qau_cmd_t cmd,
  output logic              done,
  output qau_pkg::qau_res_t result
);

  localparam int W   = qau_pkg::WORD_BITS;
  localparam int LAT = W + FRAC_BITS + 2;

  logic                     accept;
  logic [LAT-1:0]           vpipe;
  qau_pkg::word_t [3:0]     a_vec;
  qau_pkg::word_t [3:0]     b_vec;
  logic [3:0][2*W-1:0]      sq;
  qau_pkg::lane_out_t       lout [4];
  qau_pkg::scal_out_t       sout;

  // Hold off input only during reset.
  assign busy   = rst;
  assign accept = start && !busy;

  assign a_vec = {cmd.a_z, cmd.a_y, cmd.a_x, cmd.a_w};
  assign b_vec = {cmd.b_z, cmd.b_y, cmd.b_x, cmd.b_w};

  // One lane per quaternion part; lane 0 is the real part.
  for (genvar k = 0; k < 4; k++) begin : g_lane
    qau_lane #(
      .FRAC_BITS (FRAC_BITS),
      .K         (k)
    ) u_lane (
      .clk   (clk),
      .op    (cmd.func),
      .a_vec (a_vec),
      .b_vec (b_vec),
      .s     (cmd.scalar),
      .sq    (sq[k]),
      .lout  (lout[k])
    );
  end

  // Combine the lane squares into the norm outputs.
  qau_merge #(
    .FRAC_BITS (FRAC_BITS)
  ) u_merge (
    .clk  (clk),
    .op   (cmd.func),
    .sq   (sq),
    .sout (sout)
  );

  // Advance a valid bit alongside the data; payload stages run free.
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], accept};
    end
  end

  assign done = vpipe[LAT-1];

  always_comb begin
    result.res_w      = lout[0].word;
    result.res_x      = lout[1].word;
    result.res_y      = lout[2].word;
    result.res_z      = lout[3].word;
    result.res_scalar = sout.value;
    result.overflow   = lout[0].ovf | lout[1].ovf | lout[2].ovf | lout[3].ovf | sout.ovf;
    result.div_zero   = lout[0].dz;
  end

  // Every accepted word comes out after the fixed latency.
  a_latency : assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("accepted word did not produce a result on time");

  // A zero-divisor result never reports saturation.
  a_dz_no_ovf : assert property (@(posedge clk) disable iff (rst)
    done && result.div_zero |-> !result.overflow)
    else $error("div_zero result reports overflow");

  // A norm result leaves the quaternion parts clear.
  a_norm_parts : assert property (@(posedge clk) disable iff (rst)
    done && (result.res_scalar != '0) |->
      (result.res_w == '0) && (result.res_x == '0) &&
      (result.res_y == '0) && (result.res_z == '0))
    else $error("norm result with nonzero quaternion parts");

endmodule

/* rtl/qau_lane.sv */
// One quaternion part lane: products, add/sub/conjugate, saturation and a
// one-bit-per-stage restoring divider. Depends on qau_pkg.
module qau_lane #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS,
  parameter int K         = 0
) (
  input  logic                                  clk,
  input  qau_pkg::op_t                          op,
  input  qau_pkg::word_t [3:0]                  a_vec,
  input  qau_pkg::word_t [3:0]                  b_vec,
  input  qau_pkg::word_t                        s,
  output logic [2*qau_pkg::WORD_BITS-1:0]       sq,
  output qau_pkg::lane_out_t                    lout
);

  localparam int W  = qau_pkg::WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int P  = 2 * W;
  localparam int A  = 2 * W + 2;
  localparam int ND = W + F;
  localparam int NL = ND - 1;

  localparam logic signed [A-1:0] MAX_A = {{(A-W){1'b0}}, qau_pkg::WORD_MAX};
  localparam logic signed [A-1:0] MIN_A = {{(A-W){1'b1}}, qau_pkg::WORD_MIN};
  localparam logic [ND-1:0] QLIM_POS = {{(ND-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [ND-1:0] QLIM_NEG = {{(ND-W){1'b0}}, 1'b1, {(W-1){1'b0}}};

  typedef struct packed {
    logic [ND-1:0] nq;
    logic [W:0]    rem;
    logic [W-1:0]  den;
    logic          qneg;
    logic          apos;
    logic          aneg;
    logic          dz;
    logic          isdiv;
  } div_st_t;

  qau_pkg::word_t           ak;
  qau_pkg::word_t           bk;
  qau_pkg::word_t           ma [4];
  qau_pkg::word_t           mb [4];
  logic signed [P-1:0]      m [4];
  logic signed [W:0]        lin_c;
  logic signed [W:0]        lin1;
  qau_pkg::op_t             op1;
  logic signed [A-1:0]      acc_c;
  logic signed [A-1:0]      acc;
  logic signed [A-1:0]      shifted;
  qau_pkg::lane_out_t       sat_c;
  qau_pkg::lane_out_t       dl [NL];
  logic [W-1:0]             abs_a;
  logic [W-1:0]             abs_s;
  div_st_t                  dv [ND+1];
  qau_pkg::lane_out_t       fin_c;

  assign ak = a_vec[K];
  assign bk = b_vec[K];

  // Stage 1: operand select, multiply, linear ops.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      ma[j] = '0;
      mb[j] = '0;
      case (op) inside
        qau_pkg::OP_HAM: begin
          ma[j] = a_vec[qau_pkg::HAM_A[K][j]];
          mb[j] = b_vec[qau_pkg::HAM_B[K][j]];
        end
        qau_pkg::OP_SCALE: begin
          if (j == 0) begin
            ma[j] = ak;
            mb[j] = s;
          end
        end
        qau_pkg::OP_NORM_SQ, qau_pkg::OP_NORM: begin
          if (j == 0) begin
            ma[j] = ak;
            mb[j] = ak;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (op)
      qau_pkg::OP_ADD:  lin_c = $signed({ak[W-1], ak}) + $signed({bk[W-1], bk});
      qau_pkg::OP_SUB:  lin_c = $signed({ak[W-1], ak}) - $signed({bk[W-1], bk});
      qau_pkg::OP_CONJ: lin_c = (K == 0) ? $signed({ak[W-1], ak})
                                         : -$signed({ak[W-1], ak});
      default:          lin_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 4; j++) begin
      m[j] <= $signed(ma[j]) * $signed(mb[j]);
    end
    lin1 <= lin_c;
    op1  <= op;
  end

  // Product 0 of this part, the nonnegative square for the norm operations, for the norm merge.
  assign sq = m[0];

  // Stage 2: sum products or carry the linear value, scaled to the common point.
  always_comb begin
    acc_c = '0;
    case (op1) inside
      qau_pkg::OP_HAM: begin
        for (int j = 0; j < 4; j++) begin
          if (qau_pkg::HAM_NEG[K][j]) begin
            acc_c = acc_c - $signed({{2{m[j][P-1]}}, m[j]});
          end else begin
            acc_c = acc_c + $signed({{2{m[j][P-1]}}, m[j]});
          end
        end
      end
      qau_pkg::OP_SCALE: acc_c = $signed({{2{m[0][P-1]}}, m[0]});
      qau_pkg::OP_ADD, qau_pkg::OP_SUB, qau_pkg::OP_CONJ:
        acc_c = $signed({{(A-W-1){lin1[W]}}, lin1}) <<< F;
      default: acc_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    acc <= acc_c;
  end

  // Stage 3: floor shift and saturate, then delay to meet the divider.
  assign shifted = acc >>> F;

  always_comb begin
    sat_c.dz = 1'b0;
    if (shifted > MAX_A) begin
      sat_c.word = qau_pkg::WORD_MAX;
      sat_c.ovf  = 1'b1;
    end else if (shifted < MIN_A) begin
      sat_c.word = qau_pkg::WORD_MIN;
      sat_c.ovf  = 1'b1;
    end else begin
      sat_c.word = shifted[W-1:0];
      sat_c.ovf  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    dl[0] <= sat_c;
    for (int i = 1; i < NL; i++) begin
      dl[i] <= dl[i-1];
    end
  end

  // Divider: entry register, then one quotient bit per stage.
  assign abs_a = ak[W-1] ? (~ak) + W'(1) : ak;
  assign abs_s = s[W-1] ? (~s) + W'(1) : s;

  always_ff @(posedge clk) begin
    dv[0].nq    <= {abs_a, {F{1'b0}}};
    dv[0].rem   <= '0;
    dv[0].den   <= abs_s;
    dv[0].qneg  <= ak[W-1] ^ s[W-1];
    dv[0].apos  <= !ak[W-1] && (ak != '0);
    dv[0].aneg  <= ak[W-1];
    dv[0].dz    <= (s == '0);
    dv[0].isdiv <= (op == qau_pkg::OP_DIV);
  end

  for (genvar i = 0; i < ND; i++) begin : g_div
    logic [W:0] r_sh;
    logic       ge;
    div_st_t    nxt;

    assign r_sh = {dv[i].rem[W-1:0], dv[i].nq[ND-1]};
    assign ge   = r_sh >= {1'b0, dv[i].den};

    always_comb begin
      nxt     = dv[i];
      nxt.rem = ge ? r_sh - {1'b0, dv[i].den} : r_sh;
      nxt.nq  = {dv[i].nq[ND-2:0], ge};
    end

    always_ff @(posedge clk) begin
      dv[i+1] <= nxt;
    end
  end

  // Final select: divider result or the delayed product/linear result.
  always_comb begin
    fin_c = dl[NL-1];
    if (dv[ND].isdiv) begin
      fin_c.ovf = 1'b0;
      fin_c.dz  = dv[ND].dz;
      if (dv[ND].dz) begin
        if (dv[ND].apos) begin
          fin_c.word = qau_pkg::WORD_MAX;
        end else if (dv[ND].aneg) begin
          fin_c.word = qau_pkg::WORD_MIN;
        end else begin
          fin_c.word = '0;
        end
      end else if (!dv[ND].qneg) begin
        if (dv[ND].nq > QLIM_POS) begin
          fin_c.word = qau_pkg::WORD_MAX;
          fin_c.ovf  = 1'b1;
        end else begin
          fin_c.word = dv[ND].nq[W-1:0];
        end
      end else begin
        if (dv[ND].nq > QLIM_NEG) begin
          fin_c.word = qau_pkg::WORD_MIN;
          fin_c.ovf  = 1'b1;
        end else begin
          fin_c.word = (~dv[ND].nq[W-1:0]) + W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    lout <= fin_c;
  end

endmodule

/* rtl/qau_merge.sv */
// Merge stage: sums the four lane squares, then squared norm or a pipelined
// digit-by-digit square root. Depends on qau_pkg.
module qau_merge #(
  parameter int FRAC_BITS = qau_pkg::FRAC_BITS
) (
  input  logic                                    clk,
  input  qau_pkg::op_t                            op,
  input  logic [3:0][2*qau_pkg::WORD_BITS-1:0]    sq,
  output qau_pkg::scal_out_t                      sout
);

  localparam int W  = qau_pkg::WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int A  = 2 * W + 2;
  localparam int R  = W + 1;
  localparam int MD = F - 2;

  localparam logic [A-1:0] SMASK_A = {{(A-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic [R-1:0] SMASK_R = {2'b00, {(W-1){1'b1}}};

  typedef struct packed {
    logic [A-1:0] x;
    logic [R:0]   rem;
    logic [R-1:0] root;
    logic [W-2:0] alt;
    logic         alt_ovf;
    logic         nsq;
    logic         nrt;
  } sq_st_t;

  qau_pkg::op_t       op_r;
  logic [A-1:0]       sum;
  logic               nsq2;
  logic               nrt2;
  logic [A-1:0]       sum_sh;
  sq_st_t             sr [R+1];
  qau_pkg::scal_out_t fin_c;
  qau_pkg::scal_out_t md [MD];

  always_ff @(posedge clk) begin
    op_r <= op;
    sum  <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]} + {2'b00, sq[3]};
    nsq2 <= (op_r == qau_pkg::OP_NORM_SQ);
    nrt2 <= (op_r == qau_pkg::OP_NORM);
  end

  assign sum_sh = sum >> F;

  always_ff @(posedge clk) begin
    sr[0].x       <= sum;
    sr[0].rem     <= '0;
    sr[0].root    <= '0;
    sr[0].alt     <= sum_sh[W-2:0];
    sr[0].alt_ovf <= sum_sh > SMASK_A;
    sr[0].nsq     <= nsq2;
    sr[0].nrt     <= nrt2;
  end

  for (genvar i = 0; i < R; i++) begin : g_sqrt
    logic [R+2:0] rem_sh;
    logic [R+2:0] trial;
    logic [R+2:0] diff;
    logic         ge;
    sq_st_t       nxt;

    assign rem_sh = {sr[i].rem, sr[i].x[A-1:A-2]};
    assign trial  = {1'b0, sr[i].root, 2'b01};
    assign diff   = rem_sh - trial;
    assign ge     = rem_sh >= trial;

    always_comb begin
      nxt      = sr[i];
      nxt.x    = {sr[i].x[A-3:0], 2'b00};
      nxt.rem  = ge ? diff[R:0] : rem_sh[R:0];
      nxt.root = {sr[i].root[R-2:0], ge};
    end

    always_ff @(posedge clk) begin
      sr[i+1] <= nxt;
    end
  end

  always_comb begin
    fin_c = '0;
    if (sr[R].nrt) begin
      if (sr[R].root > SMASK_R) begin
        fin_c.value = {(W-1){1'b1}};
        fin_c.ovf   = 1'b1;
      end else begin
        fin_c.value = sr[R].root[W-2:0];
      end
    end else if (sr[R].nsq) begin
      fin_c.value = sr[R].alt_ovf ? {(W-1){1'b1}} : sr[R].alt;
      fin_c.ovf   = sr[R].alt_ovf;
    end
  end

  // Delay to line up with the lane divider.
  always_ff @(posedge clk) begin
    md[0] <= fin_c;
    for (int i = 1; i < MD; i++) begin
      md[i] <= md[i-1];
    end
  end

  assign sout = md[MD-1];

endmodule

/* tb/quaternion_arithmetic_unit_core_checker.sv */
// Checker for the quaternion arithmetic unit: predicts each result from the accepted
// command words and compares them field by field. Depends on qau_pkg.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_core_checker
  import qau_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  qau_cmd_t cmd,
  input  logic     done,
  input  qau_res_t result,
  output int       fail_count,
  output int       pending
);

  localparam logic signed [127:0] W_MAX = 128'sd2147483647;
  localparam logic signed [127:0] W_MIN = -128'sd2147483648;

  qau_res_t expected_results[$];

  function automatic word_t clamp_word(input logic signed [127:0] v, inout logic ovf);
    if (v > W_MAX) begin
      ovf = 1'b1;
      return WORD_MAX;
    end
    if (v < W_MIN) begin
      ovf = 1'b1;
      return WORD_MIN;
    end
    return word_t'(v[31:0]);
  endfunction

  function automatic logic [30:0] clamp_mag(input logic [127:0] v, inout logic ovf);
    if (v > 128'd2147483647) begin
      ovf = 1'b1;
      return 31'h7fffffff;
    end
    return v[30:0];
  endfunction

  function automatic logic [63:0] floor_sqrt(input logic [127:0] s);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if ({64'd0, c} * {64'd0, c} <= s) r = c;
    end
    return r;
  endfunction

  function automatic qau_res_t compute_quat(input qau_cmd_t c);
    qau_res_t r;
    logic signed [127:0] a[4];
    logic signed [127:0] b[4];
    logic signed [127:0] q[4];
    logic signed [127:0] s;
    logic [127:0] sq;
    logic ovf;
    logic dz;
    logic quat;
    a = '{128'(c.a_w), 128'(c.a_x), 128'(c.a_y), 128'(c.a_z)};
    b = '{128'(c.b_w), 128'(c.b_x), 128'(c.b_y), 128'(c.b_z)};
    s = 128'(c.scalar);
    ovf = 1'b0;
    dz = 1'b0;
    quat = 1'b1;
    r = '0;
    q = '{default: '0};
    case (c.func)
      OP_ADD: for (int k = 0; k < 4; k++) q[k] = a[k] + b[k];
      OP_SUB: for (int k = 0; k < 4; k++) q[k] = a[k] - b[k];
      OP_HAM: begin
        q[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
        q[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
        q[2] = a[0]*b[2] + a[2]*b[0] + a[3]*b[1] - a[1]*b[3];
        q[3] = a[0]*b[3] + a[3]*b[0] + a[1]*b[2] - a[2]*b[1];
        for (int k = 0; k < 4; k++) q[k] = q[k] >>> FRAC_BITS;
      end
      OP_SCALE: for (int k = 0; k < 4; k++) q[k] = (a[k] * s) >>> FRAC_BITS;
      OP_DIV: begin
        if (s == 0) begin
          dz = 1'b1;
          for (int k = 0; k < 4; k++)
            q[k] = a[k] > 0 ? W_MAX : (a[k] < 0 ? W_MIN : 128'sd0);
        end else begin
          // SV signed division truncates toward zero
          for (int k = 0; k < 4; k++) q[k] = (a[k] <<< FRAC_BITS) / s;
        end
      end
      OP_CONJ: begin
        q[0] = a[0];
        for (int k = 1; k < 4; k++) q[k] = -a[k];
      end
      default: begin
        quat = 1'b0;
        sq = '0;
        for (int k = 0; k < 4; k++) sq = sq + 128'(a[k] * a[k]);
        if (c.func == OP_NORM_SQ) r.res_scalar = clamp_mag(sq >> FRAC_BITS, ovf);
        else r.res_scalar = clamp_mag({64'd0, floor_sqrt(sq)}, ovf);
      end
    endcase
    if (quat) begin
      r.res_w = clamp_word(q[0], ovf);
      r.res_x = clamp_word(q[1], ovf);
      r.res_y = clamp_word(q[2], ovf);
      r.res_z = clamp_word(q[3], ovf);
    end
    r.overflow = ovf;
    r.div_zero = dz;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;
  assign pending = expected_results.size();

  always @(posedge clk) begin
    qau_res_t want;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected word", 64'(result.res_w), 64'd0);
      end else begin
        want = expected_results.pop_front();
        if (result.res_w !== want.res_w)
          report_mismatch("res_w", 64'(result.res_w), 64'(want.res_w));
        if (result.res_x !== want.res_x)
          report_mismatch("res_x", 64'(result.res_x), 64'(want.res_x));
        if (result.res_y !== want.res_y)
          report_mismatch("res_y", 64'(result.res_y), 64'(want.res_y));
        if (result.res_z !== want.res_z)
          report_mismatch("res_z", 64'(result.res_z), 64'(want.res_z));
        if (result.res_scalar !== want.res_scalar)
          report_mismatch("res_scalar", 64'(result.res_scalar), 64'(want.res_scalar));
        if (result.overflow !== want.overflow)
          report_mismatch("overflow", 64'(result.overflow), 64'(want.overflow));
        if (result.div_zero !== want.div_zero)
          report_mismatch("div_zero", 64'(result.div_zero), 64'(want.div_zero));
      end
    end
    if (!rst && start && !busy) expected_results.push_back(compute_quat(cmd));
  end

endmodule

/* tb/quaternion_arithmetic_unit_core_tb.sv */
// Top of the quaternion arithmetic unit testbench: clock, reset, command stimulus
// and verdict. Depends on qau_pkg, quaternion_arithmetic_unit_core and the checker.
`timescale 1ns / 1ps

module quaternion_arithmetic_unit_core_tb;
  import qau_pkg::*;

  // Leave generous slack past the pipeline depth for drain and watchdog.
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 2000;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  qau_cmd_t cmd;
  logic     done;
  qau_res_t result;
  int       fail_count;
  int       pending;
  int       idle_cycles;

  quaternion_arithmetic_unit_core u_dut (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done),
    .result(result)
  );

  quaternion_arithmetic_unit_core_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Watchdog: count cycles with neither a command nor a result accepted.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("quaternion_arithmetic_unit_core_tb NOT OK");
        $finish;
      end
    end
  end

  // Pick a word with a bias toward corner values so saturation gets hit.
  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return word_t'(0);
      3: return word_t'($urandom_range(0, 131072)) - word_t'(65536);
      4: return word_t'(signed'($urandom_range(0, 2000))) - word_t'(1000);
      5: return word_t'($urandom_range(0, 16'hffff)) << $urandom_range(0, 16);
      default: return word_t'($urandom);
    endcase
  endfunction

  function automatic qau_cmd_t random_cmd();
    qau_cmd_t c;
    c.func   = op_t'($urandom_range(0, 7));
    c.a_w    = pick_word();
    c.a_x    = pick_word();
    c.a_y    = pick_word();
    c.a_z    = pick_word();
    c.b_w    = pick_word();
    c.b_x    = pick_word();
    c.b_y    = pick_word();
    c.b_z    = pick_word();
    c.scalar = ($urandom_range(0, 7) == 0) ? word_t'(0) : pick_word();
    return c;
  endfunction

  // Hold the word until it is accepted, then drop start or go on at once.
  task automatic send_word(input qau_cmd_t c);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2));
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd   <= c;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_op(input op_t op, input word_t v, input word_t s);
    qau_cmd_t c;
    c = '{op, v, v, v, v, v, v, v, v, s};
    send_word(c);
  endtask

  initial begin
    qau_cmd_t c;
    int waited;
    rst   = 1'b1;
    start = 1'b0;
    cmd   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: every operation at the word extremes, zero divisor, mixed signs.
    for (int op = 0; op < 8; op++) begin
      send_op(op_t'(op), WORD_MAX, WORD_MAX);
      send_op(op_t'(op), WORD_MIN, WORD_MIN);
    end
    send_op(OP_DIV, WORD_MIN, word_t'(0));
    c = '{OP_DIV, 32'sd65536, -32'sd5, 32'sd0, WORD_MIN, 0, 0, 0, 0, word_t'(0)};
    send_word(c);
    c = '{OP_DIV, -32'sd7, 32'sd7, WORD_MAX, WORD_MIN, 0, 0, 0, 0, -32'sd1};
    send_word(c);
    c = '{OP_HAM, -32'sd1, 32'sd1, -32'sd65536, 32'sd3, 32'sd1, -32'sd1, 32'sd7, -32'sd2, 0};
    send_word(c);
    c = '{OP_SCALE, -32'sd1, 32'sd1, 32'sd65536, -32'sd3, 0, 0, 0, 0, 32'sd1};
    send_word(c);
    c = '{OP_NORM, 32'sd65536, 0, 0, 0, 0, 0, 0, 0, 0};
    send_word(c);
    c = '{OP_CONJ, 32'sd0, WORD_MIN, WORD_MAX, -32'sd1, 0, 0, 0, 0, 0};
    send_word(c);

    for (int n = 0; n < 1300; n++) send_word(random_cmd());
    start <= 1'b0;

    waited = 0;
    while (pending != 0 && waited < 10 * DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("quaternion_arithmetic_unit_core_tb OK");
    end else begin
      $display("quaternion_arithmetic_unit_core_tb NOT OK");
    end
    $finish;
  end

endmodule

/* quaternion_arithmetic_unit_core.f */
rtl/qau_pkg.sv
rtl/qau_lane.sv
rtl/qau_merge.sv
rtl/quaternion_arithmetic_unit_core.sv
tb/quaternion_arithmetic_unit_core_checker.sv
tb/quaternion_arithmetic_unit_core_tb.sv
